// ===== rtl/core/lzss_ring_decompressor_macros.svh =====
// ----------------------------------------------------------------------------
// lzss_ring_decompressor_macros.svh
// Assertion macros used by the decompressor RTL.
// ----------------------------------------------------------------------------
`ifndef LZSS_RING_DECOMPRESSOR_MACROS_SVH
`define LZSS_RING_DECOMPRESSOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define LZSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LZSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lzss_pkg.sv =====
// ----------------------------------------------------------------------------
// lzss_pkg
// Constants and types of the LZSS ring decompressor.
// ----------------------------------------------------------------------------
package lzss_pkg;

	localparam int RING_SIZE      = 512;
	localparam int RING_AW        = $clog2(RING_SIZE);
	localparam int MAX_MATCH      = 18;
	localparam int THRESHOLD      = 2;
	localparam int LEN_W          = $clog2(MAX_MATCH + 1);
	localparam int WRITE_POS_INIT = RING_SIZE - MAX_MATCH;
	localparam int POS_W          = 12;
	localparam logic [7:0] SPACE_BYTE = 8'h20;
	localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DECODE,
		ST_COPY_RD,
		ST_COPY_WR
	} lzss_state_t;

	typedef struct packed {
		logic               en;
		logic [RING_AW-1:0] addr;
		logic [7:0]         data;
	} ring_wr_t;

	typedef struct packed {
		logic               en;
		logic [RING_AW-1:0] addr;
	} ring_rd_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} out_push_t;

endpackage

// ===== rtl/core/lzss_ring_decompressor.sv =====
// ----------------------------------------------------------------------------
// lzss_ring_decompressor
// LZSS decompressor with a 512-byte history ring. Flag bytes select literals
// or position/length pairs; pairs replay bytes from the ring one at a time.
//
//   channel  signals                                    direction
//   input    in_valid, in_ready, in_byte,                in
//            stream_start, end_of_stream
//   result   out_valid, out_ready, out_byte, run_last    out
//
// Flag byte, pair head or literal: accepted, then decoded. A pair's second
// byte is accepted and decoded too; then each replayed byte (3 to 18 bytes)
// is read from the single ring read port, then written back and emitted.
// After reset and on each item with stream_start, a clearing pass writes
// spaces to the ring, one entry per cycle, before decoding.
// A stalled result channel holds the sequencer in its literal or pair emit step.
// ----------------------------------------------------------------------------
module lzss_ring_decompressor
	import lzss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       stream_start,
	input  logic       end_of_stream,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last
);

`include "lzss_ring_decompressor_macros.svh"

	lzss_state_t        state_q, state_d;
	logic [RING_AW-1:0] clr_addr_q;
	logic               item_held_q;
	logic [7:0]         b_q;
	logic               eos_q;
	logic [RING_AW-1:0] write_pos_q;
	logic [7:0]         flag_bits_q;
	logic [3:0]         flags_left_q;
	logic               phase_q;
	logic [7:0]         pos_low_q;
	logic [RING_AW-1:0] rd_addr_q;
	logic [LEN_W-1:0]   count_q;

	ring_wr_t           ring_wr;
	ring_rd_t           ring_rd;
	logic [7:0]         rd_data;
	out_push_t          push;
	logic               can_push;

	logic               accept;
	logic               clr_done;
	logic               is_pair, is_flag, is_lit;
	logic               decode_done;
	logic               copy_step;
	logic [POS_W-1:0]   pair_pos;
	logic [5:0]         pair_len_raw;
	logic [LEN_W-1:0]   pair_len;

	lzss_ring_mem u_ring (
		.clk     (clk),
		.wr      (ring_wr),
		.rd      (ring_rd),
		.rd_data (rd_data)
	);

	lzss_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

	assign accept   = in_valid && in_ready;
	assign clr_done = (clr_addr_q == RING_AW'(RING_SIZE - 1));

	assign is_pair = phase_q;
	assign is_flag = !phase_q && (flags_left_q == 4'd0);
	assign is_lit  = !phase_q && (flags_left_q != 4'd0) && flag_bits_q[0];

	assign pair_pos     = {b_q[7:4], pos_low_q};
	assign pair_len_raw = 6'(b_q[3:0]) + 6'(THRESHOLD + 1);
	assign pair_len     = (pair_len_raw > 6'(MAX_MATCH)) ? LEN_W'(MAX_MATCH)
	                                                     : pair_len_raw[LEN_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = stream_start ? ST_CLEAR : ST_DECODE;
				end
			end
			ST_CLEAR: begin
				if (clr_done) begin
					state_d = item_held_q ? ST_DECODE : ST_IDLE;
				end
			end
			ST_DECODE: begin
				if (is_pair) begin
					state_d = ST_COPY_RD;
				end else if (!is_lit || can_push) begin
					state_d = ST_IDLE;
				end
			end
			ST_COPY_RD: begin
				state_d = ST_COPY_WR;
			end
			ST_COPY_WR: begin
				if (can_push) begin
					state_d = (count_q == LEN_W'(1)) ? ST_IDLE : ST_COPY_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		ring_wr      = '0;
		ring_rd      = '0;
		push         = '0;
		decode_done  = 1'b0;
		copy_step    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_CLEAR: begin
				ring_wr.en   = 1'b1;
				ring_wr.addr = clr_addr_q;
				ring_wr.data = SPACE_BYTE;
			end
			ST_DECODE: begin
				decode_done = !is_lit || can_push;
				if (is_lit && can_push) begin
					ring_wr.en   = 1'b1;
					ring_wr.addr = write_pos_q;
					ring_wr.data = b_q;
					push.valid   = 1'b1;
					push.data    = b_q;
					push.last    = 1'b1;
				end
			end
			ST_COPY_RD: begin
				ring_rd.en   = 1'b1;
				ring_rd.addr = rd_addr_q;
			end
			ST_COPY_WR: begin
				if (can_push) begin
					copy_step    = 1'b1;
					ring_wr.en   = 1'b1;
					ring_wr.addr = write_pos_q;
					ring_wr.data = rd_data;
					push.valid   = 1'b1;
					push.data    = rd_data;
					push.last    = (count_q == LEN_W'(1));
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_addr_q   <= '0;
			item_held_q  <= 1'b0;
			write_pos_q  <= RING_AW'(WRITE_POS_INIT);
			flag_bits_q  <= '0;
			flags_left_q <= '0;
			phase_q      <= 1'b0;
			pos_low_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				item_held_q <= 1'b1;
				if (stream_start) begin
					clr_addr_q   <= '0;
					write_pos_q  <= RING_AW'(WRITE_POS_INIT);
					flag_bits_q  <= '0;
					flags_left_q <= '0;
					phase_q      <= 1'b0;
					pos_low_q    <= '0;
				end
			end
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + RING_AW'(1);
			end
			if (decode_done) begin
				if (is_flag) begin
					flag_bits_q  <= b_q;
					flags_left_q <= FLAGS_PER_BYTE;
					item_held_q  <= 1'b0;
				end else if (is_pair || is_lit) begin
					phase_q     <= 1'b0;
					flag_bits_q <= flag_bits_q >> 1;
					if (flags_left_q != 4'd0) begin
						flags_left_q <= flags_left_q - 4'd1;
					end
					if (is_lit) begin
						write_pos_q <= write_pos_q + RING_AW'(1);
						item_held_q <= 1'b0;
					end
				end else begin
					pos_low_q   <= b_q;
					phase_q     <= 1'b1;
					item_held_q <= 1'b0;
				end
				if (eos_q) begin
					phase_q      <= 1'b0;
					flags_left_q <= '0;
					flag_bits_q  <= '0;
					pos_low_q    <= '0;
				end
			end
			if (copy_step) begin
				write_pos_q <= write_pos_q + RING_AW'(1);
				if (count_q == LEN_W'(1)) begin
					item_held_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			b_q   <= in_byte;
			eos_q <= end_of_stream;
		end
		if (decode_done && is_pair) begin
			rd_addr_q <= pair_pos[RING_AW-1:0];
			count_q   <= pair_len;
		end
		if (copy_step) begin
			rd_addr_q <= rd_addr_q + RING_AW'(1);
			count_q   <= count_q - LEN_W'(1);
		end
	end

	`LZSS_ASSERT_NOW(a_ready_only_when_free, in_ready, !item_held_q,
		"input ready while an item is still in progress")
	`LZSS_ASSERT_NOW(a_no_push_in_clear, state_q == ST_CLEAR, !push.valid && !ring_rd.en,
		"result or ring read during clearing pass")
	`LZSS_ASSERT_NOW(a_copy_count_live,
		state_q == ST_COPY_RD || state_q == ST_COPY_WR, count_q != '0,
		"pair replay running with zero bytes left")
	`LZSS_ASSERT_NEXT(a_last_ends_item, push.valid && push.last && can_push,
		state_q == ST_IDLE && !item_held_q,
		"final byte of an item transferred but sequencer not idle")

endmodule

// ===== rtl/core/lzss_ring_mem.sv =====
// ----------------------------------------------------------------------------
// lzss_ring_mem
// History ring: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lzss_ring_mem
	import lzss_pkg::*;
(
	input  logic       clk,
	input  ring_wr_t   wr,
	input  ring_rd_t   rd,
	output logic [7:0] rd_data
);

	logic [7:0] ring_q [RING_SIZE];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			ring_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= ring_q[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/lzss_out_reg.sv =====
// ----------------------------------------------------------------------------
// lzss_out_reg
// Output register of the result channel; holds one byte until transfer.
// ----------------------------------------------------------------------------
module lzss_out_reg
	import lzss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  out_push_t  push,
	output logic       can_push,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;

	assign can_push = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_push) begin
			valid_q <= push.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_push && push.valid) begin
			byte_q <= push.data;
			last_q <= push.last;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign run_last  = last_q;

endmodule
